// ===== hw/rtl/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers for the calendar stepper; empty when synthesising.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define ASSERT_HOLD(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_HOLD(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/cdds_pkg.sv =====
// -----------------------------------------------------------------------------
// cdds_pkg
// Types, codes and date helpers shared by the calendar day stepper.
// -----------------------------------------------------------------------------
package cdds_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FWD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_BACK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SET = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FLOOR   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CEIL    = 2'd3;

  localparam logic [YEAR_W-1:0]  MIN_YEAR = 14'd1900;
  localparam logic [YEAR_W-1:0]  MAX_YEAR = 14'd9999;

  localparam logic [MONTH_W-1:0] JAN = 4'd1;
  localparam logic [MONTH_W-1:0] FEB = 4'd2;
  localparam logic [MONTH_W-1:0] APR = 4'd4;
  localparam logic [MONTH_W-1:0] JUN = 4'd6;
  localparam logic [MONTH_W-1:0] SEP = 4'd9;
  localparam logic [MONTH_W-1:0] NOV = 4'd11;
  localparam logic [MONTH_W-1:0] DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0] DAY_28    = 5'd28;
  localparam logic [DAY_W-1:0] DAY_29    = 5'd29;
  localparam logic [DAY_W-1:0] DAY_30    = 5'd30;
  localparam logic [DAY_W-1:0] DAY_31    = 5'd31;

  // Inverse of 25 modulo 2^14: multiples of 25 map onto 0 .. (2^14-1)/25.
  localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'(((1 << YEAR_W) - 1) / 25);

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    date_t             date;
  } cmd_t;

  typedef struct packed {
    date_t               date;
    logic [STATUS_W-1:0] status;
  } res_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] p;
    logic              div4;
    logic              div100;
    p      = y * INV25;
    div4   = (y[1:0] == 2'd0);
    div100 = div4 && (p <= DIV25_MAX);
    // Divisible by 100 and by 16 means divisible by 400.
    return div4 && (!div100 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic             leap);
    logic [DAY_W-1:0] len;
    case (m)
      FEB:               len = leap ? DAY_29 : DAY_28;
      APR, JUN, SEP, NOV: len = DAY_30;
      default:           len = DAY_31;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/cdds_cmd_if.sv =====
// -----------------------------------------------------------------------------
// cdds_cmd_if
// Command channel: valid/ready with function code and date to load.
// -----------------------------------------------------------------------------
interface cdds_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [cdds_pkg::FUNC_W-1:0]    func;
  logic [cdds_pkg::DAY_W-1:0]     new_day;
  logic [cdds_pkg::MONTH_W-1:0]   new_month;
  logic [cdds_pkg::YEAR_W-1:0]    new_year;

  modport source (output valid, func, new_day, new_month, new_year, input ready);
  modport sink   (input valid, func, new_day, new_month, new_year, output ready);
endinterface

// ===== hw/rtl/cdds_res_if.sv =====
// -----------------------------------------------------------------------------
// cdds_res_if
// Result channel: valid/ready with the date after a command and its status.
// -----------------------------------------------------------------------------
interface cdds_res_if;
  logic                            valid;
  logic                            ready;
  logic [cdds_pkg::DAY_W-1:0]      day_out;
  logic [cdds_pkg::MONTH_W-1:0]    month_out;
  logic [cdds_pkg::YEAR_W-1:0]     year_out;
  logic [cdds_pkg::STATUS_W-1:0]   status;

  modport source (output valid, day_out, month_out, year_out, status, input ready);
  modport sink   (input valid, day_out, month_out, year_out, status, output ready);
endinterface

// ===== hw/rtl/calendar_date_day_stepper.sv =====
// -----------------------------------------------------------------------------
// calendar_date_day_stepper
// Holds a Gregorian date and applies one set / forward / back command per item.
//
//   channel | dir | handshake     | payload
//   cmd_i   | in  | valid / ready | func, new_day, new_month, new_year
//   res_o   | out | valid / ready | day_out, month_out, year_out, status
//
// One item per cycle while results are taken; a result passes through the command
// register, then the result register with the date update.
// Reset brings the date to 1900-01-01 and empties both registers.
// A stalled result holds the result register; the command register still
// takes one more item, after which ready drops until the result moves on.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module calendar_date_day_stepper (
  input logic       clk_i,
  input logic       rst_ni,
  cdds_cmd_if.sink  cmd_i,
  cdds_res_if.source res_o
);
  import cdds_pkg::*;

  cmd_t  cmd_q;
  logic  cmd_valid_q;
  date_t date_q;
  res_t  res_q;
  res_t  res_d;
  logic  res_valid_q;
  logic  adv;

  assign adv         = !res_valid_q || res_o.ready;
  assign cmd_i.ready = !cmd_valid_q || adv;

  cdds_calc u_calc (
    .cmd_i (cmd_q),
    .cur_i (date_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q  <= 1'b0;
      res_valid_q  <= 1'b0;
      date_q.day   <= DAY_FIRST;
      date_q.month <= JAN;
      date_q.year  <= MIN_YEAR;
    end else begin
      if (cmd_i.ready) begin
        cmd_valid_q <= cmd_i.valid;
      end
      if (adv) begin
        res_valid_q <= cmd_valid_q;
        if (cmd_valid_q) begin
          date_q <= res_d.date;
        end
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      cmd_q.func       <= cmd_i.func;
      cmd_q.date.day   <= cmd_i.new_day;
      cmd_q.date.month <= cmd_i.new_month;
      cmd_q.date.year  <= cmd_i.new_year;
    end
    if (adv && cmd_valid_q) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.day_out   = res_q.date.day;
  assign res_o.month_out = res_q.date.month;
  assign res_o.year_out  = res_q.date.year;
  assign res_o.status    = res_q.status;

  `ASSERT_HOLD(a_date_range, clk_i, rst_ni, 1'b1,
    (date_q.year >= MIN_YEAR) && (date_q.year <= MAX_YEAR) &&
    (date_q.month >= JAN) && (date_q.month <= DEC) && (date_q.day >= DAY_FIRST),
    "held date out of range")
  `ASSERT_HOLD(a_res_matches_date, clk_i, rst_ni, res_valid_q, res_q.date == date_q,
    "pending result differs from held date")
  `ASSERT_HOLD(a_floor_date, clk_i, rst_ni, res_valid_q && (res_q.status == ST_FLOOR),
    (res_q.date.year == MIN_YEAR) && (res_q.date.month == JAN) &&
    (res_q.date.day == DAY_FIRST), "floor status away from floor date")
  `ASSERT_HOLD(a_stall_full, clk_i, rst_ni, !cmd_i.ready, cmd_valid_q && res_valid_q,
    "command side stalled with a free register")
  `ASSERT_NEXT(a_date_stable, clk_i, rst_ni, !(adv && cmd_valid_q), $stable(date_q),
    "held date moved without an item")

endmodule

// ===== hw/rtl/cdds_calc.sv =====
// -----------------------------------------------------------------------------
// cdds_calc
// Next-date logic: validated load, one day forward, one day back; the unused code keeps the date.
// -----------------------------------------------------------------------------
module cdds_calc (
  input  cdds_pkg::cmd_t  cmd_i,
  input  cdds_pkg::date_t cur_i,
  output cdds_pkg::res_t  res_o
);
  import cdds_pkg::*;

  logic             cur_leap;
  logic             new_leap;
  logic [DAY_W-1:0] cur_len;
  logic [DAY_W-1:0] prev_len;
  logic [DAY_W-1:0] new_len;
  logic [MONTH_W-1:0] prev_month;
  logic             set_ok;
  logic             at_floor;
  logic             at_ceil;

  always_comb begin
    cur_leap   = is_leap(cur_i.year);
    new_leap   = is_leap(cmd_i.date.year);
    cur_len    = month_len(cur_i.month, cur_leap);
    prev_month = cur_i.month - 4'd1;
    prev_len   = month_len(prev_month, cur_leap);
    new_len    = month_len(cmd_i.date.month, new_leap);

    set_ok = (cmd_i.date.month inside {[JAN:DEC]}) &&
             (cmd_i.date.year inside {[MIN_YEAR:MAX_YEAR]}) &&
             (cmd_i.date.day >= DAY_FIRST) && (cmd_i.date.day <= new_len);

    at_floor = (cur_i.year <= MIN_YEAR) && (cur_i.month == JAN) &&
               (cur_i.day == DAY_FIRST);
    at_ceil  = (cur_i.year >= MAX_YEAR) && (cur_i.month == DEC) &&
               (cur_i.day == DAY_31);
  end

  always_comb begin
    res_o.date   = cur_i;
    res_o.status = ST_OK;
    case (cmd_i.func)
      FUNC_SET: begin
        if (set_ok) begin
          res_o.date = cmd_i.date;
        end else begin
          res_o.status = ST_BAD_SET;
        end
      end
      FUNC_FWD: begin
        if (at_ceil) begin
          res_o.status = ST_CEIL;
        end else if (cur_i.day < cur_len) begin
          res_o.date.day = cur_i.day + 5'd1;
        end else begin
          res_o.date.day = DAY_FIRST;
          if (cur_i.month == DEC) begin
            res_o.date.month = JAN;
            res_o.date.year  = cur_i.year + 14'd1;
          end else begin
            res_o.date.month = cur_i.month + 4'd1;
          end
        end
      end
      FUNC_BACK: begin
        if (at_floor) begin
          res_o.status = ST_FLOOR;
        end else if (cur_i.day > DAY_FIRST) begin
          res_o.date.day = cur_i.day - 5'd1;
        end else if (cur_i.month == JAN) begin
          res_o.date.day   = DAY_31;
          res_o.date.month = DEC;
          res_o.date.year  = cur_i.year - 14'd1;
        end else begin
          res_o.date.month = prev_month;
          res_o.date.day   = prev_len;
        end
      end
      default: begin
        // Unused code: report the held date unchanged.
        res_o.status = ST_OK;
      end
    endcase
  end

endmodule

// ===== dv/tb_calendar_date_day_stepper.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_calendar_date_day_stepper
// Self-checking bench for the calendar day stepper. Directed commands cover
// rejected loads, leap days, floor and ceiling stops and the unused code.
// Random load-then-step runs follow, mixed with broken loads and noise. Both
// channels idle at random, and the result side is held off long enough to stall
// the command side. Every result is checked against a date predictor in the
// bench.
// -----------------------------------------------------------------------------
module tb_calendar_date_day_stepper;
  import cdds_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int unsigned        N_DIRECTED = 25;
  localparam int unsigned        N_RANDOM   = 1250;
  localparam int unsigned        MAX_SHOWN  = 40;

  logic clk_i;
  logic rst_ni;

  cdds_cmd_if cmd_if ();
  cdds_res_if res_if ();

  calendar_date_day_stepper uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // Predicted date, moved on as each command item is accepted.
  logic [DAY_W-1:0]   cal_day   = DAY_FIRST;
  logic [MONTH_W-1:0] cal_month = JAN;
  logic [YEAR_W-1:0]  cal_year  = MIN_YEAR;

  cmd_t cmd_pending[$];
  res_t date_expected[$];

  int n_items;
  int n_errors    = 0;
  int n_accepted  = 0;
  int n_results   = 0;
  int n_loads     = 0;
  int n_rejects   = 0;
  int n_floor     = 0;
  int n_ceil      = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  int hold_left   = 0;
  int hold_rounds = 0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic bit leap_of(input logic [YEAR_W-1:0] y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic [YEAR_W-1:0]  y);
    case (m)
      FEB:                return leap_of(y) ? DAY_29 : DAY_28;
      APR, JUN, SEP, NOV: return DAY_30;
      default:            return DAY_31;
    endcase
  endfunction

  function automatic res_t step_calendar(input cmd_t c);
    res_t r;
    r.status = ST_OK;
    case (c.func)
      FUNC_SET: begin
        if (c.date.month >= JAN && c.date.month <= DEC &&
            c.date.year >= MIN_YEAR && c.date.year <= MAX_YEAR &&
            c.date.day >= DAY_FIRST &&
            c.date.day <= days_in(c.date.month, c.date.year)) begin
          cal_day   = c.date.day;
          cal_month = c.date.month;
          cal_year  = c.date.year;
          n_loads++;
        end else begin
          r.status = ST_BAD_SET;
          n_rejects++;
        end
      end
      FUNC_FWD: begin
        if (cal_year >= MAX_YEAR && cal_month == DEC && cal_day == DAY_31) begin
          r.status = ST_CEIL;
          n_ceil++;
        end else if (cal_day < days_in(cal_month, cal_year)) begin
          cal_day = cal_day + 1'b1;
        end else begin
          cal_day = DAY_FIRST;
          if (cal_month == DEC) begin
            cal_month = JAN;
            cal_year  = cal_year + 1'b1;
          end else begin
            cal_month = cal_month + 1'b1;
          end
        end
      end
      FUNC_BACK: begin
        if (cal_year <= MIN_YEAR && cal_month == JAN && cal_day == DAY_FIRST) begin
          r.status = ST_FLOOR;
          n_floor++;
        end else if (cal_day > DAY_FIRST) begin
          cal_day = cal_day - 1'b1;
        end else if (cal_month == JAN) begin
          cal_month = DEC;
          cal_day   = DAY_31;
          cal_year  = cal_year - 1'b1;
        end else begin
          cal_month = cal_month - 1'b1;
          cal_day   = days_in(cal_month, cal_year);
        end
      end
      default: ;
    endcase
    r.date.day   = cal_day;
    r.date.month = cal_month;
    r.date.year  = cal_year;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    // keep the log short on a badly broken block
    if (n_errors <= MAX_SHOWN) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  task automatic add_cmd(input logic [FUNC_W-1:0] f, input int d, input int m,
                         input int y);
    cmd_t c;
    c.func       = f;
    c.date.day   = DAY_W'(d);
    c.date.month = MONTH_W'(m);
    c.date.year  = YEAR_W'(y);
    cmd_pending.push_back(c);
  endtask

  function automatic int idle_len();
    return ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic bit in_steady(input int n);
    return n >= 500 && n < 650;
  endfunction

  // Command driver: offer pending items, hold each until taken.
  always @(posedge clk_i) begin : cmd_driver
    cmd_t nxt;
    cmd_t seen;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        seen.func       = cmd_if.func;
        seen.date.day   = cmd_if.new_day;
        seen.date.month = cmd_if.new_month;
        seen.date.year  = cmd_if.new_year;
        date_expected.push_back(step_calendar(seen));
        n_accepted <= n_accepted + 1;
        gap_left = (hold_left != 0 || in_steady(n_accepted) ||
                    $urandom_range(0, 99) < 65) ? 0 : idle_len();
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          cmd_if.valid <= 1'b0;
        end else if (cmd_pending.size() != 0) begin
          nxt = cmd_pending.pop_front();
          cmd_if.valid     <= 1'b1;
          cmd_if.func      <= nxt.func;
          cmd_if.new_day   <= nxt.date.day;
          cmd_if.new_month <= nxt.date.month;
          cmd_if.new_year  <= nxt.date.year;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each item against the oldest prediction.
  always @(posedge clk_i) begin : res_monitor
    res_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        n_results <= n_results + 1;
        if (date_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d-%0d-%0d status %0d",
                                    res_if.year_out, res_if.month_out,
                                    res_if.day_out, res_if.status));
        end else begin
          want = date_expected.pop_front();
          if (res_if.day_out !== want.date.day)
            report_mismatch($sformatf("result %0d day_out %0d, want %0d", n_results,
                                      res_if.day_out, want.date.day));
          if (res_if.month_out !== want.date.month)
            report_mismatch($sformatf("result %0d month_out %0d, want %0d", n_results,
                                      res_if.month_out, want.date.month));
          if (res_if.year_out !== want.date.year)
            report_mismatch($sformatf("result %0d year_out %0d, want %0d", n_results,
                                      res_if.year_out, want.date.year));
          if (res_if.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d", n_results,
                                      res_if.status, want.status));
        end
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (in_steady(n_results) || $urandom_range(0, 99) < 70) begin
        res_if.ready <= 1'b1;
      end else begin
        stall_left = idle_len() - 1;
        res_if.ready <= 1'b0;
      end
    end
  end

  // Long hold-off on the result side so the command side backs up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left   <= 0;
      hold_rounds <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_rounds < 2 && n_results >= (hold_rounds == 0 ? 250 : 900)) begin
      hold_left   <= 60;
      hold_rounds <= hold_rounds + 1;
    end
  end

  initial begin : stimulus
    int                 pick;
    int                 run;
    int                 dir;
    logic [FUNC_W-1:0]  f;
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [DAY_W-1:0]   len;

    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.func      = FUNC_SET;
    cmd_if.new_day   = '0;
    cmd_if.new_month = '0;
    cmd_if.new_year  = '0;
    res_if.ready     = 1'b0;

    // directed: floor from reset, rejected loads, leap days, rollovers, ceiling
    add_cmd(FUNC_BACK, 31, 15, 16383);
    add_cmd(FUNC_SET, 29, 2, 1900);
    add_cmd(FUNC_SET, 0, 1, 2000);
    add_cmd(FUNC_SET, 1, 0, 2000);
    add_cmd(FUNC_SET, 1, 13, 2000);
    add_cmd(FUNC_SET, 31, 15, 16383);
    add_cmd(FUNC_SET, 0, 0, 0);
    add_cmd(FUNC_SET, 1, 1, 1899);
    add_cmd(FUNC_SET, 1, 1, 10000);
    add_cmd(FUNC_SET, 31, 4, 2021);
    add_cmd(FUNC_SET, 29, 2, 2000);
    add_cmd(FUNC_FWD, 0, 0, 0);
    add_cmd(FUNC_BACK, 0, 0, 0);
    add_cmd(FUNC_SET, 28, 2, 2023);
    add_cmd(FUNC_FWD, 31, 15, 16383);
    add_cmd(FUNC_SET, 31, 12, 9999);
    add_cmd(FUNC_FWD, 0, 0, 0);
    add_cmd(FUNC_BACK, 0, 0, 0);
    add_cmd(FUNC_SET, 1, 1, 2001);
    add_cmd(FUNC_BACK, 0, 0, 0);
    add_cmd(FUNC_NONE, 31, 15, 16383);
    add_cmd(FUNC_SET, 31, 1, 1900);
    add_cmd(FUNC_FWD, 0, 0, 0);
    add_cmd(FUNC_SET, 1, 1, 1900);
    add_cmd(FUNC_BACK, 0, 0, 0);

    while (cmd_pending.size() < N_DIRECTED + N_RANDOM) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        // load a date near an edge, then walk from it
        case ($urandom_range(0, 5))
          0:       y = MIN_YEAR;
          1:       y = MAX_YEAR;
          2:       y = YEAR_W'(100 * $urandom_range(19, 99));
          3:       y = YEAR_W'(4 * $urandom_range(475, 2499));
          4:       y = YEAR_W'($urandom_range(1900, 1905));
          default: y = YEAR_W'($urandom_range(1900, 9999));
        endcase
        if (y == MIN_YEAR && $urandom_range(0, 1) == 1)      m = JAN;
        else if (y == MAX_YEAR && $urandom_range(0, 1) == 1) m = DEC;
        else                                                 m = MONTH_W'($urandom_range(1, 12));
        len = days_in(m, y);
        case ($urandom_range(0, 3))
          0:       d = len;
          1:       d = len - 1'b1;
          2:       d = DAY_W'($urandom_range(1, 3));
          default: d = DAY_W'($urandom_range(1, len));
        endcase
        add_cmd(FUNC_SET, d, m, y);
        run = $urandom_range(1, 30);
        dir = $urandom_range(0, 2);
        for (int i = 0; i < run; i++) begin
          if ($urandom_range(0, 19) == 0) f = FUNC_NONE;
          else if (dir == 0)              f = FUNC_FWD;
          else if (dir == 1)              f = FUNC_BACK;
          else                            f = $urandom_range(0, 1) ? FUNC_FWD : FUNC_BACK;
          add_cmd(f, $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
        end
      end else if (pick < 86) begin
        // load with one field out of range
        y   = YEAR_W'($urandom_range(1900, 9999));
        m   = MONTH_W'($urandom_range(1, 12));
        len = days_in(m, y);
        d   = DAY_W'($urandom_range(1, len));
        case ($urandom_range(0, 2))
          0:       d = (len == DAY_31) ? '0 : len + 1'b1;
          1:       m = $urandom_range(0, 1) ? MONTH_W'($urandom_range(13, 15)) : '0;
          default: y = $urandom_range(0, 1) ? YEAR_W'($urandom_range(0, 1899))
                                            : YEAR_W'($urandom_range(10000, 16383));
        endcase
        add_cmd(FUNC_SET, d, m, y);
      end else begin
        add_cmd(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                $urandom_range(0, 15), $urandom_range(0, 16383));
      end
    end
    n_items = cmd_pending.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_items) @(posedge clk_i);
    while (date_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d commands and %0d checked results.", n_items, n_results);
    $display("Loads %0d, rejected loads %0d, floor stops %0d, ceiling stops %0d.",
             n_loads, n_rejects, n_floor, n_ceil);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d of %0d commands taken.", n_accepted, n_items);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
